@@ sv/arbb_pkg.sv @@
package arbb_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int COEF_FRAC_BITS_DEF = 24;
    localparam int REG_WIDTH          = 32;
    localparam int CFG_IDX_WIDTH      = 3;

    localparam logic signed [REG_WIDTH-1:0] COEF_ONE_RST = 32'sd16777216;
    localparam logic signed [REG_WIDTH-1:0] ZERO_RST     = '0;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5
    } t_cfg_idx;

endpackage

@@ sv/affine_rect_bounding_box.sv @@
// Affine rectangle bounding box
//
// Input beat: i_rect_left/top/width/height (signed Q16.16) is taken at a rising
// edge with i_start high and o_busy low. o_busy is always low, so one rectangle
// can be started in every cycle. The four corners are mapped through the affine
// matrix held in the configuration registers, and the axis-aligned box of the
// mapped corners comes out on o_box_left/top/width/height with o_overflow.
// Result beat: o_valid rises when the result is in the extent register and
// stays high for exactly one cycle per rectangle, beside the box outputs;
// the receiver cannot stall and must capture it in that cycle.
// Throughput is one rectangle per cycle: each of the seven stages (input
// register, corner add, multiply, min/max, sum, round/saturate, extent) takes
// a new beat every cycle, with one set of eight multipliers.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 coef_xx,
// 1 coef_xy, 2 offset_x, 3 coef_yx, 4 coef_yy, 5 offset_y); other indexes are
// ignored. Write only while no rectangle is in flight.
// Reset: synchronous on i_rst_n low; the pipeline empties and the matrix
// returns to identity with zero offsets.
module affine_rect_bounding_box
    import arbb_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic signed [COORD_WIDTH-1:0]   i_rect_left,
    input  logic signed [COORD_WIDTH-1:0]   i_rect_top,
    input  logic signed [COORD_WIDTH-1:0]   i_rect_width,
    input  logic signed [COORD_WIDTH-1:0]   i_rect_height,
    input  logic                            i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]        i_cfg_idx,
    input  logic [REG_WIDTH-1:0]            i_cfg_data,
    output logic                            o_valid,
    output logic signed [COORD_WIDTH-1:0]   o_box_left,
    output logic signed [COORD_WIDTH-1:0]   o_box_top,
    output logic [COORD_WIDTH-2:0]          o_box_width,
    output logic [COORD_WIDTH-2:0]          o_box_height,
    output logic                            o_overflow
);

    localparam int W     = COORD_WIDTH;
    localparam int F     = COEF_FRAC_BITS;
    localparam int PW    = W + REG_WIDTH;
    localparam int OW    = REG_WIDTH + F + 1;
    localparam int SW    = ((PW > OW) ? PW : OW) + 2;
    localparam int NSTG  = 7;

    // configuration
    logic signed [REG_WIDTH-1:0] r_coef_xx, r_coef_xy, r_off_x;
    logic signed [REG_WIDTH-1:0] r_coef_yx, r_coef_yy, r_off_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx <= COEF_ONE_RST;
            r_coef_xy <= ZERO_RST;
            r_off_x   <= ZERO_RST;
            r_coef_yx <= ZERO_RST;
            r_coef_yy <= COEF_ONE_RST;
            r_off_y   <= ZERO_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_COEF_XX:  r_coef_xx <= i_cfg_data;
                REG_COEF_XY:  r_coef_xy <= i_cfg_data;
                REG_OFFSET_X: r_off_x   <= i_cfg_data;
                REG_COEF_YX:  r_coef_yx <= i_cfg_data;
                REG_COEF_YY:  r_coef_yy <= i_cfg_data;
                REG_OFFSET_Y: r_off_y   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid pipeline
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;

    assign n_vld = {r_vld[NSTG-2:0], i_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_vld[NSTG-1];

    // stage 1: input register
    logic signed [W-1:0] r_l, r_t, r_w, r_h;

    always_ff @(posedge i_clk) begin
        r_l <= i_rect_left;
        r_t <= i_rect_top;
        r_w <= i_rect_width;
        r_h <= i_rect_height;
    end

    // stage 2: far corners, saturated
    logic signed [W:0]   n_rs, n_bs;
    logic signed [W-1:0] n_r, n_b;
    logic                n_ov2;
    logic signed [W-1:0] r_x0, r_x1, r_y0, r_y1;
    logic                r_ov2;

    always_comb begin
        n_rs  = {r_l[W-1], r_l} + {r_w[W-1], r_w};
        n_bs  = {r_t[W-1], r_t} + {r_h[W-1], r_h};
        n_ov2 = 1'b0;
        n_r   = n_rs[W-1:0];
        n_b   = n_bs[W-1:0];
        if (n_rs[W] != n_rs[W-1]) begin
            n_ov2 = 1'b1;
            n_r   = {n_rs[W], {(W-1){~n_rs[W]}}};
        end
        if (n_bs[W] != n_bs[W-1]) begin
            n_ov2 = 1'b1;
            n_b   = {n_bs[W], {(W-1){~n_bs[W]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0  <= r_l;
        r_x1  <= n_r;
        r_y0  <= r_t;
        r_y1  <= n_b;
        r_ov2 <= n_ov2;
    end

    // stage 3: eight products
    logic signed [PW-1:0] r_pxx0, r_pxx1, r_pxy0, r_pxy1;
    logic signed [PW-1:0] r_pyx0, r_pyx1, r_pyy0, r_pyy1;
    logic                 r_ov3;

    always_ff @(posedge i_clk) begin
        r_pxx0 <= PW'(r_x0) * PW'(r_coef_xx);
        r_pxx1 <= PW'(r_x1) * PW'(r_coef_xx);
        r_pxy0 <= PW'(r_y0) * PW'(r_coef_xy);
        r_pxy1 <= PW'(r_y1) * PW'(r_coef_xy);
        r_pyx0 <= PW'(r_x0) * PW'(r_coef_yx);
        r_pyx1 <= PW'(r_x1) * PW'(r_coef_yx);
        r_pyy0 <= PW'(r_y0) * PW'(r_coef_yy);
        r_pyy1 <= PW'(r_y1) * PW'(r_coef_yy);
        r_ov3  <= r_ov2;
    end

    // stage 4: mapping is separable, so min/max of each term pair
    logic signed [PW-1:0] r_xa_min, r_xa_max, r_xb_min, r_xb_max;
    logic signed [PW-1:0] r_ya_min, r_ya_max, r_yb_min, r_yb_max;
    logic                 r_ov4;

    always_ff @(posedge i_clk) begin
        r_xa_min <= (r_pxx0 < r_pxx1) ? r_pxx0 : r_pxx1;
        r_xa_max <= (r_pxx0 < r_pxx1) ? r_pxx1 : r_pxx0;
        r_xb_min <= (r_pxy0 < r_pxy1) ? r_pxy0 : r_pxy1;
        r_xb_max <= (r_pxy0 < r_pxy1) ? r_pxy1 : r_pxy0;
        r_ya_min <= (r_pyx0 < r_pyx1) ? r_pyx0 : r_pyx1;
        r_ya_max <= (r_pyx0 < r_pyx1) ? r_pyx1 : r_pyx0;
        r_yb_min <= (r_pyy0 < r_pyy1) ? r_pyy0 : r_pyy1;
        r_yb_max <= (r_pyy0 < r_pyy1) ? r_pyy1 : r_pyy0;
        r_ov4    <= r_ov3;
    end

    // stage 5: sums with offset and rounding constant
    logic signed [SW-1:0] n_cx, n_cy, n_half;
    logic signed [SW-1:0] r_sx_min, r_sx_max, r_sy_min, r_sy_max;
    logic                 r_ov5;

    always_comb begin
        n_half = SW'(1) <<< (F - 1);
        n_cx   = (SW'(r_off_x) <<< F) + n_half;
        n_cy   = (SW'(r_off_y) <<< F) + n_half;
    end

    always_ff @(posedge i_clk) begin
        r_sx_min <= SW'(r_xa_min) + SW'(r_xb_min) + n_cx;
        r_sx_max <= SW'(r_xa_max) + SW'(r_xb_max) + n_cx;
        r_sy_min <= SW'(r_ya_min) + SW'(r_yb_min) + n_cy;
        r_sy_max <= SW'(r_ya_max) + SW'(r_yb_max) + n_cy;
        r_ov5    <= r_ov4;
    end

    // stage 6: round and saturate to coordinate width
    function automatic logic [W:0] rnd_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] sh;
        logic [W:0]           res;
        sh = s >>> F;
        if (sh[SW-1:W-1] == {(SW-W+1){sh[W-1]}}) begin
            res = {1'b0, sh[W-1:0]};
        end else begin
            res = {1'b1, sh[SW-1], {(W-1){~sh[SW-1]}}};
        end
        return res;
    endfunction

    logic [W:0]          n_qx_min, n_qx_max, n_qy_min, n_qy_max;
    logic signed [W-1:0] r_bx_min, r_bx_max, r_by_min, r_by_max;
    logic                r_ov6;

    always_comb begin
        n_qx_min = rnd_sat(r_sx_min);
        n_qx_max = rnd_sat(r_sx_max);
        n_qy_min = rnd_sat(r_sy_min);
        n_qy_max = rnd_sat(r_sy_max);
    end

    always_ff @(posedge i_clk) begin
        r_bx_min <= n_qx_min[W-1:0];
        r_bx_max <= n_qx_max[W-1:0];
        r_by_min <= n_qy_min[W-1:0];
        r_by_max <= n_qy_max[W-1:0];
        r_ov6    <= r_ov5 | n_qx_min[W] | n_qx_max[W] | n_qy_min[W] | n_qy_max[W];
    end

    // stage 7: extents and result register
    logic [W:0]          n_dx, n_dy;
    logic                n_ovx, n_ovy;
    logic signed [W-1:0] r_box_left, r_box_top;
    logic [W-2:0]        r_box_width, r_box_height;
    logic                r_overflow;

    always_comb begin
        n_dx  = {r_bx_max[W-1], r_bx_max} - {r_bx_min[W-1], r_bx_min};
        n_dy  = {r_by_max[W-1], r_by_max} - {r_by_min[W-1], r_by_min};
        n_ovx = n_dx[W] | n_dx[W-1];
        n_ovy = n_dy[W] | n_dy[W-1];
    end

    always_ff @(posedge i_clk) begin
        r_box_left   <= r_bx_min;
        r_box_top    <= r_by_min;
        r_box_width  <= n_ovx ? {(W-1){1'b1}} : n_dx[W-2:0];
        r_box_height <= n_ovy ? {(W-1){1'b1}} : n_dy[W-2:0];
        r_overflow   <= r_ov6 | n_ovx | n_ovy;
    end

    assign o_box_left   = r_box_left;
    assign o_box_top    = r_box_top;
    assign o_box_width  = r_box_width;
    assign o_box_height = r_box_height;
    assign o_overflow   = r_overflow;

endmodule
